// ----- sv/fcdh_pkg.sv -----
// Shared types and constants for the field-centric drive heading controller.
package fcdh_pkg;

  localparam int unsigned FullTurn = 36000;
  localparam int unsigned HalfTurn = 18000;
  localparam int unsigned CordIter = 16;
  localparam int unsigned SpdScale = 994900;  // 19898 * 50

  typedef enum logic [2:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_WINDOW   = 3'd3,
    REG_TURN_DIV = 3'd4
  } reg_idx_t;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_GDIV = 13'b0000000000010,
    S_GOAL = 13'b0000000000100,
    S_ERR  = 13'b0000000001000,
    S_CORD = 13'b0000000010000,
    S_SPD  = 13'b0000000100000,
    S_PID  = 13'b0000001000000,
    S_TURN = 13'b0000010000000,
    S_MAXO = 13'b0000100000000,
    S_SCL  = 13'b0001000000000,
    S_SDIV = 13'b0010000000000,
    S_SRES = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  // CORDIC arctangent steps, 0.0001 degree
  function automatic logic signed [23:0] atan_lut(input logic [3:0] idx);
    logic signed [23:0] v;
    begin
      unique case (idx)
        4'd0:  v = 24'sd450000;
        4'd1:  v = 24'sd265651;
        4'd2:  v = 24'sd140362;
        4'd3:  v = 24'sd71250;
        4'd4:  v = 24'sd35763;
        4'd5:  v = 24'sd17899;
        4'd6:  v = 24'sd8952;
        4'd7:  v = 24'sd4476;
        4'd8:  v = 24'sd2238;
        4'd9:  v = 24'sd1119;
        4'd10: v = 24'sd560;
        4'd11: v = 24'sd280;
        4'd12: v = 24'sd140;
        4'd13: v = 24'sd70;
        4'd14: v = 24'sd35;
        default: v = 24'sd17;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- sv/field_centric_drive_heading_pid.sv -----
// Field-centric X-drive wheel speeds with PID heading hold.
// One request in, one result out. Time per item is set mostly by the shared bit-serial
// divider (one quotient bit a cycle, 54 bits per division): one division for the goal
// step and one per wheel for rescaling when no scale term is zero, plus 16 CORDIC
// iterations and the multiply steps. Inputs are taken only while the core is idle;
// a finished result waits in the output register while the next request is taken.
module field_centric_drive_heading_pid
  import fcdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // heading[15:0], stick_x, stick_y, stick_turn
  output logic        out_tvalid,
  input  logic        out_tready,
  // speed_back_left, speed_back_right, speed_front_right, speed_front_left, heading_error
  output logic [79:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int DW   = 54;
  localparam int DENW = 38;
  localparam int XW   = 26;

  state_t state_r;

  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [14:0] window_r;
  logic [7:0]  tdiv_r;

  logic [15:0]        h_r;
  logic signed [7:0]  sx_r, sy_r, st_r;
  logic [15:0]        goal_r;
  logic signed [15:0] err_r, last_err_r;
  logic signed [31:0] esum_r;
  logic [14:0]        max_axis_r;
  logic [37:0]        max_out_r;

  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [23:0]   cz_r;
  logic [3:0]           ccnt_r;
  logic [2:0]           kcnt_r;

  logic signed [47:0] prod_r;
  logic signed [49:0] acc_r;
  logic signed [38:0] turn_r;
  logic signed [38:0] sp_r [4];
  logic signed [14:0] res_r [4];
  logic               neg_r;

  logic [DW-1:0]   dnum_r;
  logic [DENW:0]   drem_r;
  logic [DENW-1:0] dden_r;
  logic [5:0]      dcnt_r;

  logic        out_valid_r;
  logic [79:0] out_data_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // divider step
  logic [DENW:0] rem_sh;
  logic          qbit;
  assign rem_sh = {drem_r[DENW-1:0], dnum_r[DW-1]};
  assign qbit   = (rem_sh >= {1'b0, dden_r});

  // CORDIC step
  logic signed [XW-1:0] xs, ys;
  assign xs = cx_r >>> ccnt_r;
  assign ys = cy_r >>> ccnt_r;

  // goal update
  logic [14:0]        gq;
  logic signed [17:0] gstep, g0, g1, g2;
  assign gq    = dnum_r[14:0];
  assign gstep = st_r[7] ? -$signed({3'b0, gq}) : $signed({3'b0, gq});
  assign g0    = $signed({2'b0, goal_r}) + gstep;
  assign g1    = (g0 >= 18'sd36000) ? g0 - 18'sd36000 : g0;
  assign g2    = (g1 <= 18'sd0) ? g1 + 18'sd36000 : g1;

  // CORDIC init
  logic signed [23:0]   z0, z1;
  logic signed [XW-1:0] x0, y0;
  assign z0 = -$signed({8'b0, h_r}) * 24'sd100;
  assign z1 = (z0 < -24'sd1800000) ? z0 + 24'sd3600000 : z0;
  assign x0 = XW'($signed({sx_r, 14'b0}));
  assign y0 = XW'($signed({sy_r, 14'b0}));

  // heading error
  logic signed [17:0] e0, e1, e2;
  assign e0 = $signed({2'b0, h_r}) - $signed({2'b0, goal_r});
  assign e1 = (e0 > 18'sd18000) ? e0 - 18'sd36000 : e0;
  assign e2 = (e1 < -18'sd18000) ? e1 + 18'sd36000 : e1;

  // integral and axis max
  logic [15:0]        err_abs;
  logic signed [32:0] sum_ext;
  logic signed [31:0] sum_sat;
  logic [14:0]        ax_x, ax_y, ax_m;
  assign err_abs = err_r[15] ? 16'(-err_r) : 16'(err_r);
  assign sum_ext = 33'(esum_r) + 33'(err_r);
  assign sum_sat = (sum_ext > 33'sd2147483647) ? 32'sh7fffffff :
                   (sum_ext < -33'sd2147483648) ? 32'sh80000000 : 32'(sum_ext);
  assign ax_x = 15'(sx_r[7] ? -16'(sx_r) : 16'(sx_r)) * 15'd100;
  assign ax_y = 15'(sy_r[7] ? -16'(sy_r) : 16'(sy_r)) * 15'd100;
  assign ax_m = (ax_y > ax_x) ? ax_y : ax_x;

  // speed terms
  logic signed [XW:0]  term;
  logic [47:0]         pmag;
  logic [18:0]         pq;
  always_comb begin
    unique case (kcnt_r)
      3'd0:    term = -(27'(cx_r) + 27'(cy_r));
      3'd1:    term = 27'(cy_r) - 27'(cx_r);
      3'd2:    term = 27'(cx_r) + 27'(cy_r);
      default: term = 27'(cx_r) - 27'(cy_r);
    endcase
  end
  assign pmag = prod_r[47] ? 48'(-prod_r) : 48'(prod_r);
  assign pq   = 19'((pmag + 48'd268435456) >> 29);

  // PID terms
  logic signed [49:0] pid_term;
  logic signed [16:0] dlt;
  assign dlt = 17'(last_err_r) - 17'(err_r);
  always_comb begin
    unique case (kcnt_r)
      3'd0:    pid_term = 50'(err_r * $signed({1'b0, gain_p_r}));
      3'd1:    pid_term = 50'(esum_r * $signed({1'b0, gain_i_r}));
      default: pid_term = 50'(dlt * $signed({1'b0, gain_d_r}));
    endcase
  end

  logic [49:0] amag;
  logic [37:0] tq;
  assign amag = acc_r[49] ? 50'(-acc_r) : 50'(acc_r);
  assign tq   = 38'((amag + 50'd2048) >> 12);

  logic signed [38:0] spn, spk;
  logic [37:0]        spn_abs, spk_abs;
  assign spk     = sp_r[kcnt_r[1:0]];
  assign spn     = spk - turn_r;
  assign spn_abs = spn[38] ? 38'(-spn) : 38'(spn);
  assign spk_abs = spk[38] ? 38'(-spk) : 38'(spk);

  logic [14:0] rq;
  assign rq = (dnum_r > DW'(10000)) ? 15'd10000 : dnum_r[14:0];

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 16'd6144;
      gain_i_r <= 16'd61;
      gain_d_r <= 16'd3277;
      window_r <= 15'd1000;
      tdiv_r   <= 8'd30;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GAIN_P:   gain_p_r <= cfg_wdata;
        REG_GAIN_I:   gain_i_r <= cfg_wdata;
        REG_GAIN_D:   gain_d_r <= cfg_wdata;
        REG_WINDOW:   window_r <= cfg_wdata[14:0];
        REG_TURN_DIV: tdiv_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      goal_r      <= '0;
      last_err_r  <= '0;
      esum_r      <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            h_r    <= (in_tdata[15:0] >= 16'd36000) ? in_tdata[15:0] - 16'd36000
                                                    : in_tdata[15:0];
            sx_r   <= $signed(in_tdata[23:16]);
            sy_r   <= $signed(in_tdata[31:24]);
            st_r   <= $signed(in_tdata[39:32]);
            dnum_r <= DW'(15'(in_tdata[39] ? 8'(-in_tdata[39:32]) : in_tdata[39:32])
                          * 15'd100);
            dden_r <= DENW'((tdiv_r == 8'd0) ? 8'd1 : tdiv_r);
            drem_r <= '0;
            dcnt_r <= '0;
            state_r <= S_GDIV;
          end
        end
        S_GDIV, S_SDIV: begin
          drem_r <= qbit ? rem_sh - {1'b0, dden_r} : rem_sh;
          dnum_r <= {dnum_r[DW-2:0], qbit};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'(DW - 1)) state_r <= (state_r == S_GDIV) ? S_GOAL : S_SRES;
        end
        S_GOAL: begin
          goal_r <= 16'(g2);
          ccnt_r <= '0;
          if (z1 > 24'sd900000) begin
            cx_r <= -x0; cy_r <= -y0; cz_r <= z1 - 24'sd1800000;
          end else if (z1 < -24'sd900000) begin
            cx_r <= -x0; cy_r <= -y0; cz_r <= z1 + 24'sd1800000;
          end else begin
            cx_r <= x0; cy_r <= y0; cz_r <= z1;
          end
          state_r <= S_ERR;
        end
        S_ERR: begin
          err_r   <= 16'(e2);
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (ccnt_r == 4'd0) begin
            esum_r     <= (err_abs < {1'b0, window_r}) ? sum_sat : 32'sd0;
            max_axis_r <= (err_abs[14:0] > ax_m) ? err_abs[14:0] : ax_m;
          end
          if (!cz_r[23]) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - atan_lut(ccnt_r);
          end else begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + atan_lut(ccnt_r);
          end
          ccnt_r <= ccnt_r + 4'd1;
          if (ccnt_r == 4'(CordIter - 1)) begin
            kcnt_r  <= '0;
            state_r <= S_SPD;
          end
        end
        S_SPD: begin
          prod_r <= 48'(term * $signed({1'b0, 20'(SpdScale)}));
          if (kcnt_r != 3'd0)
            sp_r[2'(kcnt_r - 3'd1)] <= prod_r[47] ? -39'(pq) : 39'(pq);
          kcnt_r <= (kcnt_r == 3'd4) ? 3'd0 : kcnt_r + 3'd1;
          if (kcnt_r == 3'd4) begin
            acc_r   <= '0;
            state_r <= S_PID;
          end
        end
        S_PID: begin
          acc_r  <= acc_r + pid_term;
          kcnt_r <= kcnt_r + 3'd1;
          if (kcnt_r == 3'd2) state_r <= S_TURN;
        end
        S_TURN: begin
          turn_r     <= acc_r[49] ? -39'(tq) : 39'(tq);
          last_err_r <= err_r;
          max_out_r  <= '0;
          kcnt_r     <= '0;
          state_r    <= S_MAXO;
        end
        S_MAXO: begin
          sp_r[kcnt_r[1:0]] <= spn;
          if (spn_abs > max_out_r) max_out_r <= spn_abs;
          kcnt_r <= (kcnt_r == 3'd3) ? 3'd0 : kcnt_r + 3'd1;
          if (kcnt_r == 3'd3) state_r <= S_SCL;
        end
        S_SCL: begin
          if (max_axis_r == '0 || max_out_r == '0) begin
            res_r[kcnt_r[1:0]] <= '0;
            kcnt_r <= kcnt_r + 3'd1;
            if (kcnt_r == 3'd3) state_r <= S_OUT;
          end else begin
            dnum_r  <= DW'(spk_abs * max_axis_r) + DW'(max_out_r >> 1);
            dden_r  <= max_out_r;
            drem_r  <= '0;
            dcnt_r  <= '0;
            neg_r   <= spk[38];
            state_r <= S_SDIV;
          end
        end
        S_SRES: begin
          res_r[kcnt_r[1:0]] <= neg_r ? -$signed(rq) : $signed(rq);
          kcnt_r  <= kcnt_r + 3'd1;
          state_r <= (kcnt_r == 3'd3) ? S_OUT : S_SCL;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r  <= {4'b0, err_r, res_r[3], res_r[2], res_r[1], res_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
